// ----- hw/rtl/ipv4p_pkg.sv -----
// Package: types, character codes and limits shared by the IPv4 dotted-address parser.
`timescale 1ns / 1ps
package ipv4p_pkg;

   localparam int CH_W   = 8;
   localparam int ADDR_W = 32;
   localparam int PART_W = 8;
   localparam int NPARTS = 3;

   localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_CR    = 8'h0d;
   localparam logic [CH_W-1:0] CH_LX    = 8'h78;
   localparam logic [CH_W-1:0] CH_UX    = 8'h58;
   localparam logic [CH_W-1:0] CH_LA    = 8'h61;
   localparam logic [CH_W-1:0] CH_LF    = 8'h66;
   localparam logic [CH_W-1:0] CH_UA    = 8'h41;
   localparam logic [CH_W-1:0] CH_UF    = 8'h46;

   localparam logic [ADDR_W-1:0] LIM_8  = 32'h0000_00ff;
   localparam logic [ADDR_W-1:0] LIM_16 = 32'h0000_ffff;
   localparam logic [ADDR_W-1:0] LIM_24 = 32'h00ff_ffff;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_ZERO   = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_OCT = 2'd1,
      RX_HEX = 2'd2
   } radix_type;

   typedef struct packed {
      phase_type                      phase;
      radix_type                      radix;
      logic [ADDR_W-1:0]              accum;
      logic                           ovf;
      logic [NPARTS-1:0][PART_W-1:0]  parts;
      logic [1:0]                     count;
      logic                           skip;
   } state_type;

   typedef struct packed {
      logic              emit;
      logic              accepted;
      logic [ADDR_W-1:0] address;
   } verdict_type;

endpackage

// ----- hw/rtl/ipv4p_step.sv -----
// Per-character next-state and verdict logic of the IPv4 dotted-address parser.
`timescale 1ns / 1ps
module ipv4p_step (
   input  ipv4p_pkg::state_type   cur,
   input  logic [7:0]             ch,
   output ipv4p_pkg::state_type   nxt,
   output ipv4p_pkg::verdict_type vrd
);
   import ipv4p_pkg::*;

   logic              go;
   logic              is_dig;
   logic              is_hexl;
   logic              is_hexu;
   logic              is_ws;
   logic [3:0]        dval;
   logic [ADDR_W+3:0] prod;
   logic [ADDR_W+3:0] sum;
   logic              fin_ok;
   logic [ADDR_W-1:0] fin_res;

   // finish of the string on NUL or whitespace
   always_comb begin
      fin_ok  = !cur.ovf;
      fin_res = cur.accum;
      case (cur.count)
         2'd0: begin
            fin_res = cur.accum;
         end
         2'd1: begin
            if (cur.accum > LIM_24) fin_ok = 1'b0;
            fin_res = cur.accum | {cur.parts[0], 24'd0};
         end
         2'd2: begin
            if (cur.accum > LIM_16) fin_ok = 1'b0;
            fin_res = cur.accum | {cur.parts[0], cur.parts[1], 16'd0};
         end
         default: begin
            if (cur.accum > LIM_8) fin_ok = 1'b0;
            fin_res = cur.accum | {cur.parts[0], cur.parts[1], cur.parts[2], 8'd0};
         end
      endcase
   end

   always_comb begin
      nxt     = cur;
      vrd     = '0;
      go      = 1'b1;
      is_dig  = 1'b0;
      is_hexl = 1'b0;
      is_hexu = 1'b0;
      is_ws   = 1'b0;
      dval    = '0;
      prod    = '0;
      sum     = '0;
      if (cur.skip) begin
         if (ch == CH_NUL) nxt.skip = 1'b0;
      end else begin
         case (cur.phase)
            PH_START: begin
               nxt.accum = '0;
               nxt.ovf   = 1'b0;
               if (ch == CH_ZERO) begin
                  nxt.phase = PH_ZERO;
                  nxt.radix = RX_OCT;
                  go        = 1'b0;
               end else begin
                  nxt.radix = RX_DEC;
                  nxt.phase = PH_DIGITS;
               end
            end
            PH_ZERO: begin
               nxt.phase = PH_DIGITS;
               if (ch == CH_LX || ch == CH_UX) begin
                  nxt.radix = RX_HEX;
                  go        = 1'b0;
               end else begin
                  nxt.radix = RX_OCT;
               end
            end
            default: ;
         endcase

         is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
         is_hexl = (nxt.radix == RX_HEX) && (ch >= CH_LA) && (ch <= CH_LF);
         is_hexu = (nxt.radix == RX_HEX) && (ch >= CH_UA) && (ch <= CH_UF);
         is_ws   = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
         if (is_dig)       dval = 4'(ch - CH_ZERO);
         else if (is_hexl) dval = 4'(ch - CH_LA + 8'd10);
         else              dval = 4'(ch - CH_UA + 8'd10);

         case (nxt.radix)
            RX_HEX:  prod = {nxt.accum, 4'd0};
            RX_OCT:  prod = {1'b0, nxt.accum, 3'd0};
            default: prod = {1'b0, nxt.accum, 3'd0} + {3'd0, nxt.accum, 1'b0};
         endcase
         sum = prod + {{ADDR_W{1'b0}}, dval};

         if (go) begin
            if (is_dig || is_hexl || is_hexu) begin
               if (sum[ADDR_W+3:ADDR_W] != '0) nxt.ovf = 1'b1;
               nxt.accum = sum[ADDR_W-1:0];
            end else if (ch == CH_DOT) begin
               if (cur.count == 2'd3 || nxt.accum > LIM_8 || nxt.ovf) begin
                  vrd.emit  = 1'b1;
                  nxt.phase = PH_START;
                  nxt.radix = RX_DEC;
                  nxt.accum = '0;
                  nxt.ovf   = 1'b0;
                  nxt.count = '0;
                  nxt.skip  = 1'b1;
               end else begin
                  for (int i = 0; i < NPARTS; i++) begin
                     if (cur.count == 2'(i)) nxt.parts[i] = nxt.accum[PART_W-1:0];
                  end
                  nxt.count = cur.count + 2'd1;
                  nxt.phase = PH_START;
                  nxt.radix = RX_DEC;
                  nxt.accum = '0;
                  nxt.ovf   = 1'b0;
               end
            end else begin
               vrd.emit = 1'b1;
               if (ch == CH_NUL || is_ws) begin
                  vrd.accepted = fin_ok;
                  vrd.address  = fin_ok ? fin_res : '0;
               end
               nxt.phase = PH_START;
               nxt.radix = RX_DEC;
               nxt.accum = '0;
               nxt.ovf   = 1'b0;
               nxt.count = '0;
               nxt.skip  = (ch != CH_NUL);
            end
         end
      end
   end

endmodule

// ----- hw/rtl/ipv4_dotted_address_parser_unit.sv -----
// Top level: IPv4 dotted-address parser with input register and result register.
`timescale 1ns / 1ps
// Usage:
//   req_* carries one character per beat (0 ends a string). rsp_* carries one
//   verdict beat per string: accepted flag and the host-order address (zero
//   when rejected). Characters after a verdict not raised by a NUL are dropped up
//   to and including the next NUL, then parsing restarts.
//   A character accepted into the input register is parsed by the step logic;
//   its verdict is written into the result register and shown on rsp_*.
//   Throughput: one character per cycle while rsp_* is not stalled; the parser
//   state updates in a single pass of the step logic per beat.
//   Stall: while rsp_tvalid is high and rsp_tready low, the verdict holds and
//   one more character waits in the input register; req_tready then drops.
//   Reset: synchronous, active high; clears the parse state and both
//   registers' valid flags, so the next character starts a new string.
module ipv4_dotted_address_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata     // [0] accepted, [32:1] address, [39:33] zero
);
   import ipv4p_pkg::*;

   logic              in_vld_ff,  in_vld_in;
   logic [CH_W-1:0]   in_ch_ff,   in_ch_in;
   state_type         st_ff,      st_in;
   logic              out_vld_ff, out_vld_in;
   logic              out_acc_ff, out_acc_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;

   state_type         st_nxt;
   verdict_type       vrd;
   logic              proc;

   ipv4p_step u_step (
      .cur (st_ff),
      .ch  (in_ch_ff),
      .nxt (st_nxt),
      .vrd (vrd)
   );

   always_comb begin
      proc        = in_vld_ff && (!out_vld_ff || rsp_tready);
      req_tready  = !in_vld_ff || proc;
      in_vld_in   = in_vld_ff;
      in_ch_in    = in_ch_ff;
      st_in       = st_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_acc_in  = out_acc_ff;
      out_addr_in = out_addr_ff;
      if (proc) in_vld_in = 1'b0;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
         in_ch_in  = req_tdata;
      end
      if (proc) begin
         st_in = st_nxt;
         if (vrd.emit) begin
            out_vld_in  = 1'b1;
            out_acc_in  = vrd.accepted;
            out_addr_in = vrd.address;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         st_ff.phase <= PH_START;
         st_ff.radix <= RX_DEC;
         st_ff.accum <= '0;
         st_ff.ovf   <= 1'b0;
         st_ff.parts <= '0;
         st_ff.count <= '0;
         st_ff.skip  <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         out_vld_ff  <= out_vld_in;
         st_ff.phase <= st_in.phase;
         st_ff.radix <= st_in.radix;
         st_ff.accum <= st_in.accum;
         st_ff.ovf   <= st_in.ovf;
         st_ff.parts <= st_in.parts;
         st_ff.count <= st_in.count;
         st_ff.skip  <= st_in.skip;
      end
   end

   always_ff @(posedge clock) begin
      in_ch_ff    <= in_ch_in;
      out_acc_ff  <= out_acc_in;
      out_addr_ff <= out_addr_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_addr_ff, out_acc_ff};

endmodule
